// File: src/lrt_pkg.sv
// lrt_pkg: shared constants and operation codes of the lru replacement tracker
// no dependencies; imported by the controller, the top level and the checker
package lrt_pkg;

  // transaction field widths
  localparam int FUNC_W     = 2;
  localparam int FRAME_W    = 6;
  localparam int CNT_W      = 7;
  // number of frame numbers the frame field can name
  localparam int FRAME_SPAN = 1 << FRAME_W;

  // request operations
  typedef enum logic [FUNC_W-1:0] {
    FN_TOUCH  = 2'd0,
    FN_VICTIM = 2'd1,
    FN_ERASE  = 2'd2,
    FN_NONE   = 2'd3
  } func_t;

endpackage

// File: src/lrt_link_ram.sv
// lrt_link_ram: one-write one-read synchronous memory for the link arrays
// read data is registered; no dependencies
module lrt_link_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 7
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/lrt_ctrl.sv
// lrt_ctrl: sequencer that unlinks and relinks frames in the link memories
// holds presence bits, oldest/newest pointers and the count; uses lrt_pkg
module lrt_ctrl #(
  parameter int SLOTS = 64,
  parameter int AW    = $clog2(SLOTS),
  parameter int LW    = $clog2(SLOTS + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [lrt_pkg::FUNC_W-1:0]  func,
  input  logic [lrt_pkg::FRAME_W-1:0] frame,
  output logic                        busy,
  output logic                        done,
  output logic                        ok,
  output logic [lrt_pkg::FRAME_W-1:0] victim_frame,
  output logic [lrt_pkg::CNT_W-1:0]   entry_count,
  // link memory ports
  output logic                        rd_en,
  output logic [AW-1:0]               rd_addr,
  input  logic [LW-1:0]               newer_rd,
  input  logic [LW-1:0]               older_rd,
  output logic                        newer_we,
  output logic [AW-1:0]               newer_waddr,
  output logic [LW-1:0]               newer_wdata,
  output logic                        older_we,
  output logic [AW-1:0]               older_waddr,
  output logic [LW-1:0]               older_wdata
);
  import lrt_pkg::*;

  localparam logic [LW-1:0] NONE = LW'(SLOTS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DETACH,
    S_ATTACH1,
    S_ATTACH2
  } state_t;

  state_t          state;
  logic [SLOTS-1:0] present;
  logic [LW-1:0]   oldest;
  logic [LW-1:0]   newest;
  logic [LW-1:0]   count;
  logic [AW-1:0]   cur;
  logic            relink;
  logic            is_victim;
  logic [AW-1:0]   cur_ok_idx;
  logic [LW-1:0]   count_res;

  logic            accept;
  logic            in_range;
  logic [AW-1:0]   fidx;
  logic            pres;

  // request decode
  assign accept   = start && (state == S_IDLE);
  assign in_range = (FRAME_W + 1)'(frame) < (FRAME_W + 1)'(SLOTS);
  assign fidx     = frame[AW-1:0];
  assign pres     = in_range && present[fidx];
  assign busy     = (state != S_IDLE);

  // link reads are issued at the accepting edge
  assign rd_en   = accept;
  assign rd_addr = (func_t'(func) == FN_VICTIM) ? oldest[AW-1:0] : fidx;

  // link writes per step
  always_comb begin
    newer_we    = 1'b0;
    newer_waddr = cur;
    newer_wdata = NONE;
    older_we    = 1'b0;
    older_waddr = cur;
    older_wdata = newest;
    case (state)
      S_DETACH: begin
        newer_we    = (older_rd != NONE);
        newer_waddr = older_rd[AW-1:0];
        newer_wdata = newer_rd;
        older_we    = (newer_rd != NONE);
        older_waddr = newer_rd[AW-1:0];
        older_wdata = older_rd;
      end
      S_ATTACH1: begin
        newer_we = 1'b1;
        older_we = 1'b1;
      end
      S_ATTACH2: begin
        newer_we    = (newest != NONE);
        newer_waddr = newest[AW-1:0];
        newer_wdata = LW'(cur);
      end
      default: begin
      end
    endcase
  end

  assign cur_ok_idx = cur;
  assign count_res  = count;

  // sequencer, list registers and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      present      <= '0;
      oldest       <= NONE;
      newest       <= NONE;
      count        <= '0;
      done         <= 1'b0;
      ok           <= 1'b0;
      victim_frame <= '0;
      entry_count  <= '0;
      relink       <= 1'b0;
      is_victim    <= 1'b0;
      cur          <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            // default: request finishes at once with no change
            ok           <= 1'b0;
            victim_frame <= '0;
            entry_count  <= CNT_W'(count_res);
            relink       <= 1'b0;
            is_victim    <= 1'b0;
            cur          <= fidx;
            case (func_t'(func))
              FN_TOUCH: begin
                if (!in_range) begin
                  done <= 1'b1;
                end else if (!pres) begin
                  state <= S_ATTACH1;
                end else if (LW'(fidx) == newest) begin
                  done <= 1'b1;
                  ok   <= 1'b1;
                end else begin
                  relink <= 1'b1;
                  state  <= S_DETACH;
                end
              end
              FN_VICTIM: begin
                if (oldest == NONE) begin
                  done <= 1'b1;
                end else begin
                  cur       <= oldest[AW-1:0];
                  is_victim <= 1'b1;
                  state     <= S_DETACH;
                end
              end
              FN_ERASE: begin
                if (pres) begin
                  state <= S_DETACH;
                end else begin
                  done <= 1'b1;
                end
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        S_DETACH: begin
          // unlink cur from its neighbors
          if (older_rd == NONE) begin
            oldest <= newer_rd;
          end
          if (newer_rd == NONE) begin
            newest <= older_rd;
          end
          present[cur] <= 1'b0;
          count        <= count - LW'(1);
          if (relink) begin
            state <= S_ATTACH1;
          end else begin
            state        <= S_IDLE;
            done         <= 1'b1;
            ok           <= 1'b1;
            victim_frame <= is_victim ? FRAME_W'(cur_ok_idx) : '0;
            entry_count  <= CNT_W'(count - LW'(1));
          end
        end
        S_ATTACH1: begin
          state <= S_ATTACH2;
        end
        S_ATTACH2: begin
          // hook cur behind the old newest frame
          if (newest == NONE) begin
            oldest <= LW'(cur);
          end
          newest       <= LW'(cur);
          present[cur] <= 1'b1;
          count        <= count + LW'(1);
          state        <= S_IDLE;
          done         <= 1'b1;
          ok           <= 1'b1;
          victim_frame <= '0;
          entry_count  <= CNT_W'(count + LW'(1));
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: src/lru_replacement_tracker.sv
// lru replacement tracker: start accepted when busy is low; one result per
// transaction on the done strobe. requests that change nothing answer from idle;
// victim and erase pass through detach; touch of an absent frame through attach1
// and attach2; touch that moves a frame through detach, attach1 and attach2.
// a new start is accepted only once the last result is given; no result stall
// sync reset clears presence, pointers and count; needs lrt_pkg, lrt_ctrl, lrt_link_ram
module lru_replacement_tracker #(
  parameter int FRAMES = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [lrt_pkg::FUNC_W-1:0]  func,
  input  logic [lrt_pkg::FRAME_W-1:0] frame,
  output logic                        busy,
  output logic                        done,
  output logic                        ok,
  output logic [lrt_pkg::FRAME_W-1:0] victim_frame,
  output logic [lrt_pkg::CNT_W-1:0]   entry_count
);
  import lrt_pkg::*;

  // only frames the frame field can name need storage
  localparam int SLOTS = (FRAMES < FRAME_SPAN) ? FRAMES : FRAME_SPAN;
  localparam int AW    = $clog2(SLOTS);
  localparam int LW    = $clog2(SLOTS + 1);

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [LW-1:0] newer_rd;
  logic [LW-1:0] older_rd;
  logic          newer_we;
  logic [AW-1:0] newer_waddr;
  logic [LW-1:0] newer_wdata;
  logic          older_we;
  logic [AW-1:0] older_waddr;
  logic [LW-1:0] older_wdata;

  // sequencer
  lrt_ctrl #(
    .SLOTS (SLOTS),
    .AW    (AW),
    .LW    (LW)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .func         (func),
    .frame        (frame),
    .busy         (busy),
    .done         (done),
    .ok           (ok),
    .victim_frame (victim_frame),
    .entry_count  (entry_count),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .newer_rd     (newer_rd),
    .older_rd     (older_rd),
    .newer_we     (newer_we),
    .newer_waddr  (newer_waddr),
    .newer_wdata  (newer_wdata),
    .older_we     (older_we),
    .older_waddr  (older_waddr),
    .older_wdata  (older_wdata)
  );

  // toward-newest links
  lrt_link_ram #(
    .DEPTH (SLOTS),
    .WIDTH (LW)
  ) u_newer (
    .clk   (clk),
    .we    (newer_we),
    .waddr (newer_waddr),
    .wdata (newer_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (newer_rd)
  );

  // toward-oldest links
  lrt_link_ram #(
    .DEPTH (SLOTS),
    .WIDTH (LW)
  ) u_older (
    .clk   (clk),
    .we    (older_we),
    .waddr (older_waddr),
    .wdata (older_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (older_rd)
  );

endmodule

// File: src/lrt_checker.sv
// lrt_checker: port-level assertions for the lru replacement tracker
// depends on lrt_pkg; bound to lru_replacement_tracker at the end of the file
module lrt_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic                        done,
  input logic                        ok,
  input logic [lrt_pkg::FRAME_W-1:0] victim_frame,
  input logic [lrt_pkg::CNT_W-1:0]   entry_count
);
  import lrt_pkg::*;

  // a result only shows while the block is free again
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // an accepted transaction either answers next cycle or keeps the block busy
  a_accept_follow: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy != done))
    else $error("transaction neither answered nor in progress");

  // the count never exceeds the number of frames the frame field can name
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(FRAME_SPAN))
    else $error("entry count out of range");

  // a failed request reports no victim
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !ok) |-> (victim_frame == '0))
    else $error("victim frame on failed request");

  // the reported count moves only with a result
  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !$stable(entry_count) |-> done)
    else $error("entry count changed without a result");

endmodule

bind lru_replacement_tracker lrt_checker u_lrt_checker (.*);

// File: dv/tb_top.sv
// tb_top: self-checking testbench of the lru replacement tracker
// predicts results by keeping the lru order as a queue; depends on lrt_pkg and
// lru_replacement_tracker
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lrt_pkg::*;

  localparam int IDLE_LIMIT   = 1000;
  localparam int RANDOM_ITEMS = 1600;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic               ok;
    logic [FRAME_W-1:0] victim_frame;
    logic [CNT_W-1:0]   entry_count;
  } lru_result_t;

  typedef enum int {SEG_MIXED, SEG_HOT, SEG_FILL, SEG_DRAIN} seg_kind_t;

  // lru order predictor and store of pending results
  class lru_order_sb;
    logic [FRAME_W-1:0] order_q[$];  // oldest frame first
    lru_result_t        result_q[$];
    int unsigned        err_cnt;

    function void note_request(func_t op, logic [FRAME_W-1:0] fr);
      lru_result_t r;
      int          idx;
      r   = '0;
      idx = -1;
      foreach (order_q[i]) if (order_q[i] == fr) idx = i;
      case (op)
        FN_TOUCH: begin
          r.ok = 1'b1;
          if (idx < 0) begin
            order_q.push_back(fr);
          end else if (idx != order_q.size() - 1) begin
            order_q.delete(idx);
            order_q.push_back(fr);
          end
        end
        FN_VICTIM: begin
          if (order_q.size() > 0) begin
            r.ok           = 1'b1;
            r.victim_frame = order_q.pop_front();
          end
        end
        FN_ERASE: begin
          if (idx >= 0) begin
            r.ok = 1'b1;
            order_q.delete(idx);
          end
        end
        default: ;
      endcase
      r.entry_count = CNT_W'(order_q.size());
      result_q.push_back(r);
    endfunction

    function void check_result(logic ok, logic [FRAME_W-1:0] vf, logic [CNT_W-1:0] cnt);
      lru_result_t e;
      if (result_q.size() == 0) begin
        $error("result with no transaction pending: ok %0d victim_frame %0d entry_count %0d",
               ok, vf, cnt);
        err_cnt++;
        return;
      end
      e = result_q.pop_front();
      if (ok !== e.ok) begin
        $error("ok mismatch: expected %0d, actual %0d", e.ok, ok);
        err_cnt++;
      end
      if (vf !== e.victim_frame) begin
        $error("victim_frame mismatch: expected %0d, actual %0d", e.victim_frame, vf);
        err_cnt++;
      end
      if (cnt !== e.entry_count) begin
        $error("entry_count mismatch: expected %0d, actual %0d", e.entry_count, cnt);
        err_cnt++;
      end
    endfunction

    function int pending();
      return result_q.size();
    endfunction
  endclass

  logic               clk   = 1'b0;
  logic               rst   = 1'b1;
  logic               start = 1'b0;
  logic [FUNC_W-1:0]  func  = FN_TOUCH;
  logic [FRAME_W-1:0] frame = '0;
  logic               busy;
  logic               done;
  logic               ok;
  logic [FRAME_W-1:0] victim_frame;
  logic [CNT_W-1:0]   entry_count;

  lru_order_sb sb = new();
  int          n_sent     = 0;
  int          burst_left = 1;

  always #5 clk = ~clk;

  lru_replacement_tracker i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .func         (func),
    .frame        (frame),
    .busy         (busy),
    .done         (done),
    .ok           (ok),
    .victim_frame (victim_frame),
    .entry_count  (entry_count)
  );

  // monitor: check the result first, then note a new transaction
  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_result(ok, victim_frame, entry_count);
      if (start && !busy) sb.note_request(func_t'(func), frame);
    end
  end

  // watchdog on cycles with no transaction and no result
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || done) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("tb_top: FAIL");
    $finish;
  end

  // present one transaction, wait for acceptance, then pace the bursts
  task automatic send(input func_t op, input logic [FRAME_W-1:0] fr);
    int gap;
    start <= 1'b1;
    func  <= op;
    frame <= fr;
    do @(posedge clk); while (busy);
    if (op != FN_NONE) n_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      // some bursts run back to back, others end in a gap
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  function automatic func_t pick_func(int w_touch, int w_victim, int w_erase);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < w_touch) return FN_TOUCH;
    if (roll < w_touch + w_victim) return FN_VICTIM;
    if (roll < w_touch + w_victim + w_erase) return FN_ERASE;
    return FN_NONE;
  endfunction

  // one random segment of a given flavor
  task automatic run_segment(input seg_kind_t kind);
    int                 len;
    int                 base;
    int                 j;
    logic [FRAME_W-1:0] perm[FRAME_SPAN];
    logic [FRAME_W-1:0] tmp;
    len = $urandom_range(10, 80);
    case (kind)
      SEG_MIXED: begin
        repeat (len) send(pick_func(50, 20, 25), FRAME_W'($urandom_range(0, FRAME_SPAN - 1)));
      end
      SEG_HOT: begin
        // small working set: many hits, moves and erases of tracked frames
        base = $urandom_range(0, FRAME_SPAN - 8);
        repeat (len) send(pick_func(60, 15, 20), FRAME_W'(base + $urandom_range(0, 7)));
      end
      SEG_FILL: begin
        // touch every frame once in shuffled order, then reorder
        for (int i = 0; i < FRAME_SPAN; i++) perm[i] = FRAME_W'(i);
        for (int i = FRAME_SPAN - 1; i > 0; i--) begin
          j       = $urandom_range(0, i);
          tmp     = perm[i];
          perm[i] = perm[j];
          perm[j] = tmp;
        end
        for (int i = 0; i < FRAME_SPAN; i++) send(FN_TOUCH, perm[i]);
        repeat (len) send(pick_func(85, 5, 10), FRAME_W'($urandom_range(0, FRAME_SPAN - 1)));
      end
      default: begin
        repeat (len) send(pick_func(5, 75, 15), FRAME_W'($urandom_range(0, FRAME_SPAN - 1)));
      end
    endcase
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: empty order, ignored operation, moves from every position
    send(FN_VICTIM, 6'd63);
    send(FN_ERASE, 6'd5);
    send(FN_NONE, 6'd63);
    send(FN_TOUCH, 6'd0);
    send(FN_TOUCH, 6'd63);
    send(FN_TOUCH, 6'd21);
    send(FN_TOUCH, 6'd42);
    send(FN_TOUCH, 6'd0);
    send(FN_TOUCH, 6'd0);
    send(FN_TOUCH, 6'd21);
    send(FN_ERASE, 6'd42);
    send(FN_ERASE, 6'd63);
    send(FN_ERASE, 6'd21);
    send(FN_ERASE, 6'd21);
    send(FN_NONE, 6'd0);
    send(FN_TOUCH, 6'd63);
    send(FN_VICTIM, 6'd42);
    send(FN_VICTIM, 6'd21);
    send(FN_VICTIM, 6'd0);

    // random: mixed, hot set, full fill and drain segments
    while (n_sent < RANDOM_ITEMS) run_segment(seg_kind_t'($urandom_range(0, 3)));

    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.err_cnt == 0 && sb.pending() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
